// ===== design/i2cms_pkg.sv =====
`default_nettype none
package i2cms_pkg;

	localparam logic [2:0] CMD_IDLE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;
	localparam logic [2:0] CMD_PROBE = 3'd5;
	localparam logic [2:0] CMD_CHECK = 3'd6;

	localparam logic [5:0] PHASES_START = 6'd3;
	localparam logic [5:0] PHASES_STOP  = 6'd3;
	localparam logic [5:0] PHASES_WRITE = 6'd27;
	localparam logic [5:0] PHASES_READ  = 6'd18;
	localparam logic [5:0] PHASES_CHECK = 6'd4;
	localparam logic [5:0] PHASES_PROBE = PHASES_START + PHASES_WRITE + PHASES_STOP;
	localparam logic [5:0] WRITE_ACK_PHASE = 6'd25;
	localparam logic [5:0] WRITE_DATA_PHASES = 6'd24;
	localparam logic [5:0] READ_DATA_PHASES = 6'd16;

	localparam logic [7:0] PHASE_TICKS_RESET = 8'd40;

	localparam logic [2:0] LINE_OK            = 3'd0;
	localparam logic [2:0] LINE_SCL_NO_LOW    = 3'd1;
	localparam logic [2:0] LINE_SCL_STUCK_LOW = 3'd2;
	localparam logic [2:0] LINE_SDA_NO_LOW    = 3'd3;
	localparam logic [2:0] LINE_SDA_STUCK_LOW = 3'd4;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [0:0] REG_PHASE_TICKS = 1'b0;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] tx_byte;
		logic       master_ack;
		logic       sda_in;
		logic       scl_in;
	} cmd_item_t;

	typedef struct packed {
		logic       scl_drive;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       nack;
		logic [2:0] line_status;
		logic       rejected;
	} res_item_t;

endpackage
`default_nettype wire

// ===== design/i2cms_cmd_if.sv =====
`default_nettype none
interface i2cms_cmd_if;
	logic                 valid;
	logic                 ready;
	i2cms_pkg::cmd_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/i2cms_res_if.sv =====
`default_nettype none
interface i2cms_res_if;
	logic                 valid;
	logic                 ready;
	i2cms_pkg::res_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/i2c_master_bit_sequencer_top.sv =====
// channel | dir | handshake    | payload
// cmd     | in  | valid/ready  | opcode, tx_byte, master_ack, sda_in, scl_in (one tick)
// res     | out | valid/ready  | scl_drive, sda_drive, busy_res, done_res, rx_byte,
//         |     |              | nack, line_status, rejected (one per tick)
// apb     | in  | psel/penable | phase_ticks at byte address 0, pready always high
//
// One tick per cycle while res is not stalled: a transfer enters the input register,
// then the sequencer state and the result register update together from it.
// The result is valid from the result register until res takes it.
// A stalled res holds the result register; the input register takes a tick only if empty.
// arst_n clears the sequencer to idle with both lines released and phase_ticks at 40.
`default_nettype none
module i2c_master_bit_sequencer_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	i2cms_cmd_if.sink                               cmd,
	i2cms_res_if.source                             res,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [i2cms_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [i2cms_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [i2cms_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                    pready
);
	import i2cms_pkg::*;

	function automatic logic [1:0] drive_start(input logic [5:0] p, input logic scl,
			input logic sda);
		logic [1:0] r;
		r = {scl, sda};
		if (p == 6'd0) r = 2'b11;
		else if (p == 6'd1) r[0] = 1'b0;
		else r[1] = 1'b0;
		return r;
	endfunction

	function automatic logic [1:0] drive_stop(input logic [5:0] p, input logic scl,
			input logic sda);
		logic [1:0] r;
		r = {scl, sda};
		if (p == 6'd0) r[0] = 1'b0;
		else if (p == 6'd1) r[1] = 1'b1;
		else r[0] = 1'b1;
		return r;
	endfunction

	function automatic logic [1:0] drive_write(input logic [5:0] p, input logic [1:0] sub,
			input logic wbit, input logic scl, input logic sda);
		logic [1:0] r;
		r = {scl, sda};
		if (p < WRITE_DATA_PHASES) begin
			if (sub == 2'd0) r[0] = wbit;
			else if (sub == 2'd1) r[1] = 1'b1;
			else r[1] = 1'b0;
		end else if (p == WRITE_DATA_PHASES) begin
			r[0] = 1'b1;
		end else if (p == WRITE_ACK_PHASE) begin
			r[1] = 1'b1;
		end else begin
			r[1] = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [1:0] drive_phase(input logic [2:0] c, input logic [5:0] p,
			input logic [1:0] sub, input logic wbit, input logic ackc, input logic scl,
			input logic sda);
		logic [1:0] r;
		r = {scl, sda};
		case (c)
			CMD_START: r = drive_start(p, scl, sda);
			CMD_STOP:  r = drive_stop(p, scl, sda);
			CMD_WRITE: r = drive_write(p, sub, wbit, scl, sda);
			CMD_READ: begin
				if (p < READ_DATA_PHASES) begin
					if (!p[0]) begin
						if (p == 6'd0) r[0] = 1'b1;
						r[1] = 1'b1;
					end else begin
						r[1] = 1'b0;
					end
				end else if (p == READ_DATA_PHASES) begin
					r = {1'b1, ~ackc};
				end else begin
					r[1] = 1'b0;
				end
			end
			CMD_PROBE: begin
				if (p < PHASES_START) r = drive_start(p, scl, sda);
				else if (p < PHASES_START + PHASES_WRITE)
					r = drive_write(p - PHASES_START, sub, wbit, scl, sda);
				else r = drive_stop(p - PHASES_START - PHASES_WRITE, scl, sda);
			end
			CMD_CHECK: begin
				if (p == 6'd0) r[1] = 1'b0;
				else if (p == 6'd1) r[1] = 1'b1;
				else if (p == 6'd2) r[0] = 1'b0;
				else r[0] = 1'b1;
			end
			default: r = {scl, sda};
		endcase
		return r;
	endfunction

	function automatic logic [5:0] phase_total(input logic [2:0] c);
		logic [5:0] r;
		case (c)
			CMD_START: r = PHASES_START;
			CMD_STOP:  r = PHASES_STOP;
			CMD_WRITE: r = PHASES_WRITE;
			CMD_READ:  r = PHASES_READ;
			CMD_PROBE: r = PHASES_PROBE;
			CMD_CHECK: r = PHASES_CHECK;
			default:   r = 6'd0;
		endcase
		return r;
	endfunction

	// configuration
	logic [7:0] phase_ticks_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PHASE_TICKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RESET;
		end else if (cfg_wr) begin
			phase_ticks_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PHASE_TICKS) prdata[7:0] = phase_ticks_q;
	end

	// input register and handshake
	cmd_item_t item_s1;
	logic      valid_s1;
	res_item_t out_data_q;
	logic      out_valid_q;
	logic      advance;

	assign advance   = valid_s1 && (!out_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) item_s1 <= cmd.data;
	end

	// sequencer state
	logic [2:0] act_q, act_n;
	logic [5:0] ph_q, ph_n;
	logic [7:0] tk_q, tk_n;
	logic [7:0] sh_q, sh_n;
	logic       scl_q, scl_n, sda_q, sda_n;
	logic       ack_q, ack_n, ackc_q, ackc_n;
	logic [2:0] code_q, code_n;
	logic [7:0] rx_q, rx_n;
	logic [1:0] sub_q, sub_n;
	logic [2:0] bit_q, bit_n;
	logic       done, rej, early, op_valid, phase_end;
	logic [6:0] nxt;
	logic [1:0] lv;
	logic [2:0] code;

	assign op_valid  = (item_s1.opcode >= CMD_START) && (item_s1.opcode <= CMD_CHECK);
	assign phase_end = ({1'b0, tk_q} + 9'd1) >= {1'b0, phase_ticks_q};
	assign nxt       = {1'b0, ph_q} + 7'd1;

	always_comb begin
		act_n  = act_q;
		ph_n   = ph_q;
		tk_n   = tk_q;
		sh_n   = sh_q;
		scl_n  = scl_q;
		sda_n  = sda_q;
		ack_n  = ack_q;
		ackc_n = ackc_q;
		code_n = code_q;
		rx_n   = rx_q;
		sub_n  = sub_q;
		bit_n  = bit_q;
		done   = 1'b0;
		rej    = 1'b0;
		early  = 1'b0;
		code   = LINE_OK;
		lv     = {scl_q, sda_q};
		if (act_q == CMD_IDLE) begin
			if (op_valid) begin
				act_n = item_s1.opcode;
				ph_n  = 6'd0;
				tk_n  = 8'd0;
				sub_n = 2'd0;
				bit_n = 3'd0;
				if (item_s1.opcode == CMD_WRITE || item_s1.opcode == CMD_PROBE)
					sh_n = item_s1.tx_byte;
				else if (item_s1.opcode == CMD_READ)
					sh_n = 8'd0;
				if (item_s1.opcode == CMD_READ) ackc_n = item_s1.master_ack;
				lv = drive_phase(item_s1.opcode, 6'd0, 2'd0, item_s1.tx_byte[7], ackc_n,
					scl_q, sda_q);
				scl_n = lv[1];
				sda_n = lv[0];
			end
		end else begin
			rej = op_valid;
			if (phase_end) begin
				// sample at the end of the current phase
				if (act_q == CMD_WRITE && ph_q == WRITE_ACK_PHASE) begin
					ack_n = item_s1.sda_in;
				end else if (act_q == CMD_PROBE && ph_q == PHASES_START + WRITE_ACK_PHASE) begin
					ack_n = item_s1.sda_in;
				end else if (act_q == CMD_READ && ph_q < READ_DATA_PHASES && !ph_q[0]) begin
					sh_n = {sh_q[6:0], item_s1.sda_in};
				end else if (act_q == CMD_CHECK) begin
					if (ph_q == 6'd0 && item_s1.scl_in) code = LINE_SCL_NO_LOW;
					else if (ph_q == 6'd1 && !item_s1.scl_in) code = LINE_SCL_STUCK_LOW;
					else if (ph_q == 6'd2 && item_s1.sda_in) code = LINE_SDA_NO_LOW;
					else if (ph_q == 6'd3 && !item_s1.sda_in) code = LINE_SDA_STUCK_LOW;
					if (code != LINE_OK || ph_q == 6'd3) begin
						code_n = code;
						early  = 1'b1;
					end
				end
				tk_n = 8'd0;
				if (early || nxt >= {1'b0, phase_total(act_q)}) begin
					if (act_q == CMD_READ) begin
						rx_n  = sh_n;
						sda_n = 1'b1;
					end
					act_n = CMD_IDLE;
					ph_n  = 6'd0;
					done  = 1'b1;
				end else begin
					ph_n = nxt[5:0];
					// track bit and sub-phase of the byte-write section
					if (act_q == CMD_PROBE && nxt[5:0] == PHASES_START) begin
						sub_n = 2'd0;
						bit_n = 3'd0;
					end else if (sub_q == 2'd2) begin
						sub_n = 2'd0;
						bit_n = bit_q + 3'd1;
					end else begin
						sub_n = sub_q + 2'd1;
					end
					lv = drive_phase(act_q, nxt[5:0], sub_n, sh_q[3'd7 - bit_n], ackc_q,
						scl_q, sda_q);
					scl_n = lv[1];
					sda_n = lv[0];
				end
			end else begin
				tk_n = tk_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= CMD_IDLE;
			ph_q   <= 6'd0;
			tk_q   <= 8'd0;
			sh_q   <= 8'd0;
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
			ack_q  <= 1'b0;
			ackc_q <= 1'b0;
			code_q <= LINE_OK;
			rx_q   <= 8'd0;
			sub_q  <= 2'd0;
			bit_q  <= 3'd0;
		end else if (advance) begin
			act_q  <= act_n;
			ph_q   <= ph_n;
			tk_q   <= tk_n;
			sh_q   <= sh_n;
			scl_q  <= scl_n;
			sda_q  <= sda_n;
			ack_q  <= ack_n;
			ackc_q <= ackc_n;
			code_q <= code_n;
			rx_q   <= rx_n;
			sub_q  <= sub_n;
			bit_q  <= bit_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.scl_drive   <= scl_n;
			out_data_q.sda_drive   <= sda_n;
			out_data_q.busy_res    <= (act_n != CMD_IDLE);
			out_data_q.done_res    <= done;
			out_data_q.rx_byte     <= rx_n;
			out_data_q.nack        <= ack_n;
			out_data_q.line_status <= code_n;
			out_data_q.rejected    <= rej;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_data_q;

endmodule
`default_nettype wire

// ===== design/i2cms_checker.sv =====
`default_nettype none
module i2cms_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       res_valid,
	input wire logic                       res_ready,
	input wire i2cms_pkg::res_item_t       res_data
);
	import i2cms_pkg::*;

	logic last_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_busy_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			last_busy_q <= res_data.busy_res;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("stalled result changed");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.done_res |-> !res_data.busy_res)
		else $error("done reported while still busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res_data.done_res |-> last_busy_q)
		else $error("done without a running command");

	a_reject_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res_data.rejected |-> last_busy_q)
		else $error("command rejected while idle");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.line_status <= LINE_SDA_STUCK_LOW))
		else $error("line status code out of range");

endmodule

bind i2c_master_bit_sequencer_top i2cms_checker u_i2cms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
`default_nettype wire
